[hdl/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types, sizes and command codes for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

	// queue sizes, tied to the field widths below
	localparam int NUM_PRIOS = 64;
	localparam int NUM_TASKS = 32;
	localparam int PRIO_W    = 6;
	localparam int TASK_W    = 5;
	localparam int CNT_W     = 6;

	typedef enum logic [2:0] {
		CMD_INS_TAIL = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_REMOVE   = 3'd2,
		CMD_ROTATE   = 3'd3,
		CMD_QUERY    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [4:0] task_id;
		logic [5:0] task_prio;
	} req_t;

	typedef struct packed {
		logic       status;
		logic       any_ready;
		logic [5:0] highest_prio;
		logic [4:0] head_task;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // capture request and read the tables
		logic update;   // write the link tables
		logic respond;  // compute result
	} dp_cmd_t;

endpackage

[hdl/prq_datapath.sv]
// ----------------------------------------------------------------------------
// prq_datapath
// List tables, bitmap and link update logic of the ready queue.
// ----------------------------------------------------------------------------
module prq_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  prq_pkg::req_t    req,
	input  prq_pkg::dp_cmd_t dcmd,
	output prq_pkg::rsp_t    rsp
);
	localparam int NP = prq_pkg::NUM_PRIOS;
	localparam int NT = prq_pkg::NUM_TASKS;
	localparam int TW = prq_pkg::TASK_W;
	localparam int PW = prq_pkg::PRIO_W;
	localparam int CW = prq_pkg::CNT_W;
	localparam logic [PW-1:0] NIL = '1;

	// per-priority tables, only meaningful while the bitmap bit is set
	logic [PW-1:0] head_q  [NP];
	logic [PW-1:0] tail_q  [NP];
	logic [CW-1:0] count_q [NP];

	// per-task link registers
	logic [PW-1:0] next_q  [NT];
	logic [PW-1:0] prev_q  [NT];
	logic [NT-1:0] ready_q;
	logic [PW-1:0] level_q [NT];
	logic [NP-1:0] bitmap_q;

	prq_pkg::req_t req_q;
	logic          status_q;
	logic          act_q;

	// captured operands, read in the load cycle
	logic [PW-1:0] p_s1, h_s1, tl_s1, nx_s1, pv_s1;
	logic [CW-1:0] cnt_s1;
	logic          live_s1;

	// result registers, read in the respond cycle
	logic          any_s2;
	logic [PW-1:0] first_s2;
	logic [PW-1:0] hh_s2;

	// decode of the incoming request
	logic t_ok, p_ok, is_ins, is_rem;
	logic [PW-1:0] pr;
	always_comb begin
		t_ok   = 32'(req.task_id) < NT;
		p_ok   = 32'(req.task_prio) < NP;
		is_ins = req.cmd == prq_pkg::CMD_INS_TAIL || req.cmd == prq_pkg::CMD_INS_HEAD;
		is_rem = req.cmd == prq_pkg::CMD_REMOVE;
		pr     = is_rem ? (t_ok ? level_q[req.task_id] : '0) : req.task_prio;
	end

	// lowest set bit of the bitmap
	logic [PW-1:0] first_p;
	logic          any_p;
	always_comb begin
		first_p = '0;
		any_p   = 1'b0;
		for (int i = NP - 1; i >= 0; i--) begin
			if (bitmap_q[i]) begin
				first_p = PW'(i);
				any_p   = 1'b1;
			end
		end
	end

	function automatic logic tok(input logic [PW-1:0] t);
		return 32'(t) < NT;
	endfunction

	// operands of the update step
	logic [CW-1:0] cnt;
	logic          rot_ok;
	logic [PW-1:0] nh;
	logic [PW-1:0] id;
	logic [TW-1:0] ti;
	always_comb begin
		cnt    = live_s1 ? cnt_s1 : '0;
		rot_ok = cnt > CW'(1);
		ti     = req_q.task_id;
		id     = PW'(req_q.task_id);
		nh     = tok(h_s1) ? next_q[h_s1[TW-1:0]] : NIL;
	end

	// per-priority table writes
	logic          hd_we, tl_we, ct_we;
	logic [PW-1:0] hd_wd, tl_wd;
	logic [CW-1:0] ct_wd;
	always_comb begin
		hd_we = 1'b0;
		tl_we = 1'b0;
		ct_we = 1'b0;
		hd_wd = NIL;
		tl_wd = NIL;
		ct_wd = '0;
		if (dcmd.update && act_q) begin
			unique case (prq_pkg::cmd_t'(req_q.cmd)) inside
				prq_pkg::CMD_INS_TAIL, prq_pkg::CMD_INS_HEAD: begin
					ct_we = 1'b1;
					ct_wd = cnt + CW'(1);
					if (cnt == '0) begin
						hd_we = 1'b1;
						hd_wd = id;
						tl_we = 1'b1;
						tl_wd = id;
					end else if (req_q.cmd == prq_pkg::CMD_INS_HEAD) begin
						hd_we = 1'b1;
						hd_wd = id;
					end else begin
						tl_we = 1'b1;
						tl_wd = id;
					end
				end
				prq_pkg::CMD_REMOVE: begin
					ct_we = cnt != '0;
					ct_wd = cnt - CW'(1);
					if (cnt <= CW'(1)) begin
						hd_we = 1'b1;
						tl_we = 1'b1;
					end else if (pv_s1 == NIL) begin
						hd_we = 1'b1;
						hd_wd = nx_s1;
					end else if (nx_s1 == NIL) begin
						tl_we = 1'b1;
						tl_wd = pv_s1;
					end
				end
				prq_pkg::CMD_ROTATE: begin
					// head moves to the tail, its successor becomes head
					if (rot_ok) begin
						hd_we = 1'b1;
						hd_wd = nh;
						tl_we = 1'b1;
						tl_wd = h_s1;
					end
				end
				default: ;
			endcase
		end
	end

	// per-priority tables: registered reads, one write per command
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			h_s1   <= head_q[pr];
			tl_s1  <= tail_q[pr];
			cnt_s1 <= count_q[pr];
		end
		if (dcmd.respond) hh_s2 <= head_q[first_p];
		if (hd_we) head_q[p_s1] <= hd_wd;
		if (tl_we) tail_q[p_s1] <= tl_wd;
		if (ct_we) count_q[p_s1] <= ct_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				next_q[i]  <= NIL;
				prev_q[i]  <= NIL;
				level_q[i] <= '0;
			end
			ready_q  <= '0;
			bitmap_q <= '0;
			status_q <= 1'b0;
			act_q    <= 1'b0;
			req_q    <= '0;
			p_s1     <= '0;
			nx_s1    <= NIL;
			pv_s1    <= NIL;
			live_s1  <= 1'b0;
			any_s2   <= 1'b0;
			first_s2 <= '0;
		end else begin
			// capture request and read operands
			if (dcmd.load) begin
				req_q    <= req;
				p_s1     <= pr;
				live_s1  <= bitmap_q[pr];
				nx_s1    <= t_ok ? next_q[req.task_id] : NIL;
				pv_s1    <= t_ok ? prev_q[req.task_id] : NIL;
				status_q <= 1'b0;
				act_q    <= 1'b0;
				if (is_ins) begin
					status_q <= !t_ok || !p_ok || (t_ok && ready_q[req.task_id]);
					act_q    <= t_ok && p_ok && !ready_q[req.task_id];
				end else if (is_rem) begin
					status_q <= !t_ok || !ready_q[req.task_id];
					act_q    <= t_ok && ready_q[req.task_id] && 32'(pr) < NP;
				end else if (req.cmd == prq_pkg::CMD_ROTATE) begin
					act_q <= p_ok;
				end
			end

			// link and bitmap writes
			if (dcmd.update && act_q) begin
				unique case (prq_pkg::cmd_t'(req_q.cmd)) inside
					prq_pkg::CMD_INS_TAIL, prq_pkg::CMD_INS_HEAD: begin
						ready_q[ti]    <= 1'b1;
						level_q[ti]    <= p_s1;
						bitmap_q[p_s1] <= 1'b1;
						if (cnt == '0) begin
							next_q[ti] <= NIL;
							prev_q[ti] <= NIL;
						end else if (req_q.cmd == prq_pkg::CMD_INS_HEAD) begin
							next_q[ti] <= h_s1;
							prev_q[ti] <= NIL;
							if (tok(h_s1)) prev_q[h_s1[TW-1:0]] <= id;
						end else begin
							prev_q[ti] <= tl_s1;
							next_q[ti] <= NIL;
							if (tok(tl_s1)) next_q[tl_s1[TW-1:0]] <= id;
						end
					end
					prq_pkg::CMD_REMOVE: begin
						if (cnt <= CW'(1)) begin
							bitmap_q[p_s1] <= 1'b0;
						end else if (pv_s1 == NIL) begin
							if (tok(nx_s1)) prev_q[nx_s1[TW-1:0]] <= NIL;
						end else if (nx_s1 == NIL) begin
							if (tok(pv_s1)) next_q[pv_s1[TW-1:0]] <= NIL;
						end else begin
							if (tok(pv_s1)) next_q[pv_s1[TW-1:0]] <= nx_s1;
							if (tok(nx_s1)) prev_q[nx_s1[TW-1:0]] <= pv_s1;
						end
						next_q[ti]  <= NIL;
						prev_q[ti]  <= NIL;
						ready_q[ti] <= 1'b0;
					end
					prq_pkg::CMD_ROTATE: begin
						if (rot_ok) begin
							if (tok(h_s1)) begin
								prev_q[h_s1[TW-1:0]] <= tl_s1;
								next_q[h_s1[TW-1:0]] <= NIL;
							end
							if (tok(tl_s1)) next_q[tl_s1[TW-1:0]] <= h_s1;
							if (tok(nh)) prev_q[nh[TW-1:0]] <= NIL;
						end
					end
					default: ;
				endcase
			end

			// result from the updated bitmap
			if (dcmd.respond) begin
				any_s2   <= any_p;
				first_s2 <= first_p;
			end
		end
	end

	// result fields
	always_comb begin
		rsp.status       = status_q;
		rsp.any_ready    = any_s2;
		rsp.highest_prio = any_s2 ? first_s2 : '0;
		rsp.head_task    = (any_s2 && hh_s2 != NIL) ? hh_s2[TW-1:0] : '0;
	end

endmodule

[hdl/prq_ctrl.sv]
// ----------------------------------------------------------------------------
// prq_ctrl
// Command sequencer: load, update, respond, strobe.
// ----------------------------------------------------------------------------
module prq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output prq_pkg::dp_cmd_t dcmd
);
	typedef enum logic [1:0] {S_IDLE, S_UPD, S_RSP, S_OUT} state_t;
	state_t state_q;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

	always_comb begin
		dcmd         = '0;
		dcmd.load    = state_q == S_IDLE && start;
		dcmd.update  = state_q == S_UPD;
		dcmd.respond = state_q == S_RSP;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start) state_q <= S_UPD;
				S_UPD:   state_q <= S_RSP;
				S_RSP:   state_q <= S_OUT;
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/priority_ready_queue.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue
// Bitmap priority ready queue with per-priority linked task lists.
// ----------------------------------------------------------------------------
// result strobe: done is high in the out state, after the update and respond states
// a new command is taken only once idle, after the load/update/respond/out sequence
// reset: bitmap and task links clear at once; list tables are only read while
// their bitmap bit is set, so they need no clearing
// the result strobe cannot be stalled by the receiver
module priority_ready_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  prq_pkg::req_t req,
	output logic          done,
	output prq_pkg::rsp_t rsp
);
	prq_pkg::dp_cmd_t dcmd;

	prq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.busy(busy), .done(done), .dcmd(dcmd)
	);

	prq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .dcmd(dcmd), .rsp(rsp)
	);

	// no transfer while a command is in flight
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	// a strobe follows every accepted command
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("missing result");
	// reported priority is zero when nothing is ready
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.any_ready) |-> (rsp.highest_prio == '0 && rsp.head_task == '0))
		else $error("bad empty result");
endmodule
